>>> rtl/core/fmr_pkg.sv
package fmr_pkg;

  // register reset value
  localparam logic [7:0] START_MARKER_RST = 8'd95;

  // checksum base: expected = base - length - data sum
  localparam logic [7:0] CHK_BASE = 8'hFF;

  // receiver phase
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  // one result transaction
  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic       frame_end;
    logic       checksum_ok;
    logic [7:0] frame_length;
  } result_t;

endpackage

>>> rtl/core/fmr_ifs.sv
// received byte channel
interface fmr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// result channel
interface fmr_out_if;
  logic       valid;
  logic       ready;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [7:0] data_index;
  logic       frame_end;
  logic       checksum_ok;
  logic [7:0] frame_length;

  modport source (output valid, output data_valid, output data_byte, output data_index,
                  output frame_end, output checksum_ok, output frame_length, input ready);
  modport sink (input valid, input data_valid, input data_byte, input data_index,
                input frame_end, input checksum_ok, input frame_length, output ready);
endinterface

// start marker register write channel
interface fmr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] start_marker;

  modport source (output valid, output start_marker, input ready);
  modport sink (input valid, input start_marker, output ready);
endinterface

>>> rtl/core/fmr_parser.sv
module fmr_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        start_marker,
  output fmr_pkg::result_t  result
);

  fmr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] length_r, length_nxt;
  logic [7:0] taken_r, taken_nxt;
  logic [7:0] sum_r, sum_nxt;

  logic [7:0] body_count;
  logic       last_byte;
  logic [7:0] expect_chk;

  // body length in bytes, checksum included
  assign body_count = (length_r <= 8'd2) ? 8'd1 : (length_r - 8'd1);
  assign last_byte  = ({1'b0, taken_r} + 9'd1) >= {1'b0, body_count};
  assign expect_chk = fmr_pkg::CHK_BASE - length_r - sum_r;

  // next state and result for the byte in hand
  always_comb begin
    phase_nxt  = phase_r;
    length_nxt = length_r;
    taken_nxt  = taken_r;
    sum_nxt    = sum_r;
    result     = '0;
    unique case (phase_r)
      fmr_pkg::PH_LEN: begin
        length_nxt          = rx_byte;
        taken_nxt           = '0;
        sum_nxt             = '0;
        phase_nxt           = fmr_pkg::PH_BODY;
        result.frame_length = rx_byte;
      end
      fmr_pkg::PH_BODY: begin
        result.frame_length = length_r;
        if (last_byte) begin
          result.frame_end   = 1'b1;
          result.checksum_ok = (expect_chk == rx_byte);
          phase_nxt          = fmr_pkg::PH_HUNT;
        end else begin
          result.data_valid = 1'b1;
          result.data_byte  = rx_byte;
          result.data_index = taken_r;
          sum_nxt           = sum_r + rx_byte;
          taken_nxt         = taken_r + 8'd1;
        end
      end
      default: begin
        // hunting, and the unused phase code
        phase_nxt = (rx_byte == start_marker) ? fmr_pkg::PH_LEN : fmr_pkg::PH_HUNT;
      end
    endcase
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= fmr_pkg::PH_HUNT;
      length_r <= '0;
      taken_r  <= '0;
      sum_r    <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      taken_r  <= taken_nxt;
      sum_r    <= sum_nxt;
    end
  end

endmodule

>>> rtl/core/framed_message_receiver.sv
// Framed message receiver.
// in_bus carries received bytes; every accepted byte yields exactly one
// result transaction on out_bus. A byte equal to the start marker opens a
// frame, the next byte is the length L, then max(L-1,1) body bytes follow,
// the last of them a checksum. Data bytes come out with their index; the
// checksum byte comes out with frame_end and checksum_ok.
// cfg_bus writes the start marker; it is always ready. The marker must be
// written only while no byte is in flight; the block does not enforce it.
// A byte accepted on in_bus passes the input register, then the result
// register, before its result is on out_bus. Throughput: one byte per
// cycle while out_bus does not stall; the frame state update is a compare,
// an 8-bit add and a counter step between those two registers.
// Reset clears the pipeline, returns to hunting and sets the start marker
// to 95. When out_bus stalls, the result register holds; in_bus ready
// follows out_bus ready in the same cycle once the input register is full,
// so at most one byte waits there while the stall lasts.
module framed_message_receiver (
  input logic       clk,
  input logic       rst_n,
  fmr_in_if.sink    in_bus,
  fmr_out_if.source out_bus,
  fmr_cfg_if.sink   cfg_bus
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  fmr_pkg::result_t out_res_r;
  fmr_pkg::result_t res;
  logic [7:0] start_marker_r;
  logic       adv;

  // stage 1 moves into the result register when that register frees up
  assign adv          = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || adv;
  assign cfg_bus.ready = 1'b1;

  // start marker register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= fmr_pkg::START_MARKER_RST;
    end else if (cfg_bus.valid) begin
      start_marker_r <= cfg_bus.start_marker;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_byte_r <= in_bus.rx_byte;
    end
  end

  // frame tracking and result forming
  fmr_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (adv),
    .rx_byte      (s1_byte_r),
    .start_marker (start_marker_r),
    .result       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.data_valid   = out_res_r.data_valid;
  assign out_bus.data_byte    = out_res_r.data_byte;
  assign out_bus.data_index   = out_res_r.data_index;
  assign out_bus.frame_end    = out_res_r.frame_end;
  assign out_bus.checksum_ok  = out_res_r.checksum_ok;
  assign out_bus.frame_length = out_res_r.frame_length;

endmodule
